@@ design/lr_pkg.sv @@
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants of the line rasterizer: request codes, color
// width and the control flags passed from line setup to the stepping core.
// ----------------------------------------------------------------------------
package lr_pkg;

  // Color width (fixed RGB888)
  localparam int COLOR_BITS = 24;

  // Request kinds carried on the input tuser
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // Line orientation flags from setup
  typedef struct packed {
    logic y_is_major;     // y is the incrementing axis
    logic minor_dir_neg;  // minor coordinate walks downward
  } lr_ctrl_t;

endpackage

@@ design/lr_setup.sv @@
// ----------------------------------------------------------------------------
// lr_setup
// Line setup: picks the major axis from the absolute deltas (ties go to y),
// orders the endpoints so the major coordinate increments, and returns the
// start point, the major end coordinate, both deltas and the minor direction.
// ----------------------------------------------------------------------------
module lr_setup
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic signed [COORD_BITS-1:0] x2,
  input  logic signed [COORD_BITS-1:0] y2,
  output logic signed [COORD_BITS-1:0] start_x,
  output logic signed [COORD_BITS-1:0] start_y,
  output logic signed [COORD_BITS-1:0] major_end,
  output logic        [COORD_BITS:0]   delta_major,
  output logic        [COORD_BITS:0]   delta_minor,
  output lr_ctrl_t                     ctrl
);

  localparam int C = COORD_BITS;

  logic signed [C:0] dx, dy, dmin;
  logic        [C:0] adx, ady;
  logic              y_major, swap;
  logic signed [C-1:0] sx1, sy1, sx2, sy2;

  always_comb begin
    // Raw deltas and their magnitudes
    dx  = $signed({x2[C-1], x2}) - $signed({x1[C-1], x1});
    dy  = $signed({y2[C-1], y2}) - $signed({y1[C-1], y1});
    adx = dx[C] ? $unsigned(-dx) : $unsigned(dx);
    ady = dy[C] ? $unsigned(-dy) : $unsigned(dy);

    // Axis choice and endpoint ordering
    y_major = !(ady < adx);
    swap    = y_major ? (y1 > y2) : (x1 > x2);
    sx1     = swap ? x2 : x1;
    sy1     = swap ? y2 : y1;
    sx2     = swap ? x1 : x2;
    sy2     = swap ? y1 : y2;

    // Signed minor delta after ordering
    dmin = y_major ? ($signed({sx2[C-1], sx2}) - $signed({sx1[C-1], sx1}))
                   : ($signed({sy2[C-1], sy2}) - $signed({sy1[C-1], sy1}));

    start_x            = sx1;
    start_y            = sy1;
    major_end          = y_major ? sy2 : sx2;
    delta_major        = y_major ? ady : adx;
    delta_minor        = dmin[C] ? $unsigned(-dmin) : $unsigned(dmin);
    ctrl.y_is_major    = y_major;
    ctrl.minor_dir_neg = dmin[C];
  end

endmodule

@@ design/lr_core.sv @@
// ----------------------------------------------------------------------------
// lr_core
// Bresenham stepping core: holds the line state, forms the pixel for the
// current item (start or step) and advances the position and error term
// by one major-axis step when a valid item that is not the last is consumed.
// ----------------------------------------------------------------------------
module lr_core
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic                         req_type,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] start_major_end,
  input  logic        [COORD_BITS:0]   start_delta_major,
  input  logic        [COORD_BITS:0]   start_delta_minor,
  input  lr_ctrl_t                     start_ctrl,
  input  logic        [COLOR_BITS-1:0] start_color,
  output logic signed [COORD_BITS-1:0] px,
  output logic signed [COORD_BITS-1:0] py,
  output logic        [COLOR_BITS-1:0] pixel_color,
  output logic                         pixel_valid,
  output logic                         last_pixel
);

  localparam int C = COORD_BITS;
  localparam int E = COORD_BITS + 3;
  localparam logic [C-1:0] ONE = {{(C-1){1'b0}}, 1'b1};

  // Line state
  logic signed [C-1:0]     cur_x, cur_y, major_end;
  logic signed [E-1:0]     err_term;
  logic        [C:0]       delta_major, delta_minor;
  lr_ctrl_t                ctrl;
  logic                    line_active;
  logic [COLOR_BITS-1:0]   held_color;

  // Source values for this item
  logic                    is_start;
  logic signed [C-1:0]     src_x, src_y, src_mend, maj, minr, maj_adv, min_adv;
  logic signed [E-1:0]     src_err, err_adv, dmin2, dmaj2;
  logic        [C:0]       src_dmaj, src_dmin;
  lr_ctrl_t                src_ctrl;
  logic [COLOR_BITS-1:0]   src_color;
  logic                    last, err_pos;
  logic signed [C-1:0]     x_adv, y_adv;

  always_comb begin
    is_start  = (req_type == REQ_START);
    src_x     = is_start ? start_x : cur_x;
    src_y     = is_start ? start_y : cur_y;
    src_mend  = is_start ? start_major_end : major_end;
    src_dmaj  = is_start ? start_delta_major : delta_major;
    src_dmin  = is_start ? start_delta_minor : delta_minor;
    src_ctrl  = is_start ? start_ctrl : ctrl;
    src_color = is_start ? start_color : held_color;

    dmin2   = $signed({1'b0, src_dmin, 1'b0});
    dmaj2   = $signed({1'b0, src_dmaj, 1'b0});
    // Initial decision variable: 2*dminor - dmajor
    src_err = is_start ? (dmin2 - $signed({2'b0, src_dmaj})) : err_term;

    // Emit
    maj  = src_ctrl.y_is_major ? src_y : src_x;
    minr = src_ctrl.y_is_major ? src_x : src_y;
    last = (maj == src_mend);

    // One Bresenham step
    err_pos = !src_err[E-1] && (src_err != '0);
    maj_adv = maj + ONE;
    if (err_pos) begin
      min_adv = src_ctrl.minor_dir_neg ? (minr - ONE) : (minr + ONE);
      err_adv = src_err + dmin2 - dmaj2;
    end else begin
      min_adv = minr;
      err_adv = src_err + dmin2;
    end
    x_adv = src_ctrl.y_is_major ? min_adv : maj_adv;
    y_adv = src_ctrl.y_is_major ? maj_adv : min_adv;

    // Result; an idle step gives an all-zero invalid beat
    pixel_valid = is_start || line_active;
    px          = pixel_valid ? src_x : '0;
    py          = pixel_valid ? src_y : '0;
    pixel_color = pixel_valid ? src_color : '0;
    last_pixel  = pixel_valid && last;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (fire && pixel_valid) begin
      line_active <= !last;
    end
  end

  // Line payload state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      err_term    <= '0;
      major_end   <= '0;
      delta_major <= '0;
      delta_minor <= '0;
      ctrl        <= '0;
      held_color  <= '0;
    end else if (fire && pixel_valid) begin
      cur_x       <= last ? src_x : x_adv;
      cur_y       <= last ? src_y : y_adv;
      err_term    <= last ? src_err : err_adv;
      major_end   <= src_mend;
      delta_major <= src_dmaj;
      delta_minor <= src_dmin;
      ctrl        <= src_ctrl;
      held_color  <= src_color;
    end
  end

endmodule

@@ design/line_rasterizer.sv @@
// Data path: input register, then the stepping logic, then the result register
// feeding m_t*. Throughput: one beat per cycle while m_tready does not stall;
// each item is one Bresenham step, a single add and compare on the error term.
// Reset (rst, synchronous, active high) empties both registers and leaves
// the rasterizer idle with no active line; all line state clears to zero.
// ----------------------------------------------------------------------------
// line_rasterizer
// Integer Bresenham line drawer for all octants. A start beat loads both
// endpoints and a color and returns the first pixel; each step beat returns
// the next pixel, with tlast on the final endpoint.
// ----------------------------------------------------------------------------
module line_rasterizer
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // x_start, y_start, x_end, y_end, line_color (low to high), zero padded
  input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_tdata,
  // req_type
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // px, py, pixel_color (low to high), zero padded
  output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] m_tdata,
  // pixel_valid
  output logic m_tuser,
  // last_pixel
  output logic m_tlast
);

  localparam int C      = COORD_BITS;
  localparam int IN_W   = ((4*C+COLOR_BITS+7)/8)*8;
  localparam int OUT_W  = ((2*C+COLOR_BITS+7)/8)*8;
  localparam int OUT_PAD = OUT_W - (2*C + COLOR_BITS);

  // Input register
  logic                  in_valid;
  logic                  in_req;
  logic [IN_W-1:0]       in_data;
  logic                  fire;

  logic signed [C-1:0]   st_x, st_y, st_mend, r_px, r_py;
  logic        [C:0]     st_dmaj, st_dmin;
  lr_ctrl_t              st_ctrl;
  logic [COLOR_BITS-1:0] r_color;
  logic                  r_valid, r_last;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req  <= s_tuser;
      in_data <= s_tdata;
    end
  end

  // Endpoint ordering and deltas
  lr_setup #(.COORD_BITS(C)) u_setup (
    .x1          (in_data[C-1:0]),
    .y1          (in_data[2*C-1:C]),
    .x2          (in_data[3*C-1:2*C]),
    .y2          (in_data[4*C-1:3*C]),
    .start_x     (st_x),
    .start_y     (st_y),
    .major_end   (st_mend),
    .delta_major (st_dmaj),
    .delta_minor (st_dmin),
    .ctrl        (st_ctrl)
  );

  // Stepping core
  lr_core #(.COORD_BITS(C)) u_core (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .req_type          (in_req),
    .start_x           (st_x),
    .start_y           (st_y),
    .start_major_end   (st_mend),
    .start_delta_major (st_dmaj),
    .start_delta_minor (st_dmin),
    .start_ctrl        (st_ctrl),
    .start_color       (in_data[4*C+COLOR_BITS-1:4*C]),
    .px                (r_px),
    .py                (r_py),
    .pixel_color       (r_color),
    .pixel_valid       (r_valid),
    .last_pixel        (r_last)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  generate
    if (OUT_PAD > 0) begin : g_pad
      always_ff @(posedge clk) begin
        if (fire) begin
          m_tdata <= {{OUT_PAD{1'b0}}, r_color, r_py, r_px};
          m_tuser <= r_valid;
          m_tlast <= r_last;
        end
      end
    end else begin : g_nopad
      always_ff @(posedge clk) begin
        if (fire) begin
          m_tdata <= {r_color, r_py, r_px};
          m_tuser <= r_valid;
          m_tlast <= r_last;
        end
      end
    end
  endgenerate

  // An idle step beat carries no pixel and no last mark
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (!m_tlast && m_tdata == '0))
    else $error("idle result beat carries data");

  // A consumed item always lands in the result register
  a_fire_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("consumed item produced no result beat");

  // A held item with a stalled output blocks new input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while pipeline is full");

  // A start beat always yields a pixel
  a_start_valid: assert property (@(posedge clk) disable iff (rst)
    (fire && in_req == REQ_START) |=> m_tuser)
    else $error("start beat produced no pixel");

endmodule

@@ bench/tb_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// tb_line_rasterizer
// Self-checking bench for the Bresenham line rasterizer. Start and step beats
// go in on s_t*; a shadow Bresenham walker predicts every pixel beat, and the
// m_t* beats are compared in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_line_rasterizer
  import lr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB   = 12;
  localparam int SW   = ((4*CB+COLOR_BITS+7)/8)*8;
  localparam int MW   = ((2*CB+COLOR_BITS+7)/8)*8;
  localparam int NUM_ITEMS = 1300;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic signed [CB-1:0]   px;
    logic signed [CB-1:0]   py;
    logic [COLOR_BITS-1:0]  color;
    logic                   valid;
    logic                   last;
  } pixel_t;

  logic          clk;
  logic          rst;
  logic          s_tvalid;
  logic          s_tready;
  logic [SW-1:0] s_tdata;
  logic          s_tuser;
  logic          m_tvalid;
  logic          m_tready;
  logic [MW-1:0] m_tdata;
  logic          m_tuser;
  logic          m_tlast;

  line_rasterizer #(.COORD_BITS(CB)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Shadow walker state
  logic signed [CB-1:0]  walk_x;
  logic signed [CB-1:0]  walk_y;
  logic signed [14:0]    walk_err;
  logic signed [CB-1:0]  walk_major_end;
  logic [12:0]           walk_dmajor;
  logic [12:0]           walk_dminor;
  lr_ctrl_t              walk_ctrl;
  logic                  walk_active;
  logic [COLOR_BITS-1:0] walk_color;

  pixel_t pixel_q[$];
  int     items_sent;
  int     mismatches;
  bit     no_idle;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #5ms;
    $display("** line_rasterizer: FAILED **");
    $finish;
  end

  // Predict the pixel beat caused by one request and advance the walker
  function automatic pixel_t predict_pixel(logic req, logic [SW-1:0] d);
    pixel_t p;
    int x1, y1, x2, y2, t, adx, ady, dmin, step;
    p = '0;
    if (req == REQ_START) begin
      x1 = $signed(d[CB-1:0]);
      y1 = $signed(d[2*CB-1:CB]);
      x2 = $signed(d[3*CB-1:2*CB]);
      y2 = $signed(d[4*CB-1:3*CB]);
      adx = (x2 - x1 < 0) ? x1 - x2 : x2 - x1;
      ady = (y2 - y1 < 0) ? y1 - y2 : y2 - y1;
      // ties go to y-major
      walk_ctrl.y_is_major = !(ady < adx);
      // swap so the major coordinate increments
      if (walk_ctrl.y_is_major ? (y1 > y2) : (x1 > x2)) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
      if (walk_ctrl.y_is_major) begin
        walk_dmajor    = 13'(y2 - y1);
        dmin           = x2 - x1;
        walk_major_end = CB'(y2);
      end else begin
        walk_dmajor    = 13'(x2 - x1);
        dmin           = y2 - y1;
        walk_major_end = CB'(x2);
      end
      walk_ctrl.minor_dir_neg = (dmin < 0);
      walk_dminor = 13'(dmin < 0 ? -dmin : dmin);
      walk_err    = 15'(2 * int'(walk_dminor) - int'(walk_dmajor));
      walk_x      = CB'(x1);
      walk_y      = CB'(y1);
      walk_color  = d[4*CB+COLOR_BITS-1:4*CB];
      walk_active = 1'b1;
    end else if (!walk_active) begin
      return p;
    end
    // emit the current pixel
    p.px    = walk_x;
    p.py    = walk_y;
    p.color = walk_color;
    p.valid = 1'b1;
    p.last  = ((walk_ctrl.y_is_major ? walk_y : walk_x) == walk_major_end);
    walk_active = !p.last;
    // step toward the next pixel
    if (walk_active) begin
      step = walk_ctrl.minor_dir_neg ? -1 : 1;
      if (walk_err > 0) begin
        if (walk_ctrl.y_is_major) walk_x = CB'(walk_x + step);
        else                      walk_y = CB'(walk_y + step);
        walk_err = 15'(int'(walk_err) + 2 * (int'(walk_dminor) - int'(walk_dmajor)));
      end else begin
        walk_err = 15'(int'(walk_err) + 2 * int'(walk_dminor));
      end
      if (walk_ctrl.y_is_major) walk_y = CB'(walk_y + 1);
      else                      walk_x = CB'(walk_x + 1);
    end
    return p;
  endfunction

  // Send one request beat; the expected pixel is queued on acceptance
  task automatic send_req(logic req, logic [SW-1:0] d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    pixel_q.push_back(predict_pixel(req, d));
    items_sent++;
  endtask

  task automatic start_line(int x0, int y0, int x1, int y1, logic [COLOR_BITS-1:0] c);
    send_req(REQ_START, {c, CB'(y1), CB'(x1), CB'(y0), CB'(x0)});
  endtask

  task automatic step_pixel();
    // endpoint and color fields are don't-care on a step
    send_req(REQ_STEP, SW'({$urandom, $urandom, $urandom}));
  endtask

  // Start a line and walk it for at most max_steps steps
  task automatic draw_line(int x0, int y0, int x1, int y1,
                           logic [COLOR_BITS-1:0] c, int max_steps);
    int n;
    n = 0;
    start_line(x0, y0, x1, y1, c);
    while (walk_active && n < max_steps) begin
      step_pixel();
      n++;
    end
  endtask

  // Hold off input until every queued pixel has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  function automatic int clamp_coord(int v);
    if (v < -2048) return -2048;
    if (v > 2047)  return 2047;
    return v;
  endfunction

  // Output side: random stalls on m_tready
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Compare each pixel beat with the oldest prediction
  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.px    = m_tdata[CB-1:0];
      got.py    = m_tdata[2*CB-1:CB];
      got.color = m_tdata[2*CB+COLOR_BITS-1:2*CB];
      got.valid = m_tuser;
      got.last  = m_tlast;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("[%0t] unexpected beat: px=%0d py=%0d color=%06h valid=%0b last=%0b",
                   $realtime, got.px, got.py, got.color, got.valid, got.last);
      end else begin
        want = pixel_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("[%0t] mismatch: exp px=%0d py=%0d color=%06h valid=%0b last=%0b",
                     $realtime, want.px, want.py, want.color, want.valid, want.last,
                     " | got px=%0d py=%0d color=%06h valid=%0b last=%0b",
                     got.px, got.py, got.color, got.valid, got.last);
        end
      end
    end
  end

  // Single-point lines and steps with no line in flight
  task automatic test_points_and_idle();
    step_pixel();
    draw_line(5, 5, 5, 5, 24'h000000, 0);
    step_pixel();
    draw_line(-2048, -2048, -2048, -2048, 24'hFFFFFF, 0);
    step_pixel();
  endtask

  // Octants, swaps, ties and extremes, with a restart mid-line
  task automatic test_octants();
    draw_line(3, 0, 0, 2, 24'h123456, 8);       // x-major, swapped, minor down
    draw_line(0, 0, -1, -3, 24'hA5A5A5, 8);     // y-major, swapped
    draw_line(2, 0, 0, 2, 24'h5A5A5A, 8);       // tie goes to y-major
    draw_line(2047, -2048, -2048, 2047, 24'hFFFFFF, 3); // full-span diagonal, cut short
    draw_line(-2048, 2047, 2047, 2047, 24'h800001, 2);  // full-span horizontal
    step_pixel();
  endtask

  // Mostly complete random lines, some cut off, plus noise
  task automatic test_random_lines();
    int x0, y0, x1, y1, span, sel;
    wait_drained();
    while (items_sent < NUM_ITEMS + 25) begin
      // stretch of back-to-back beats on both sides
      no_idle = (items_sent > 600 && items_sent < 760);
      // let the pipe drain now and then
      if ($urandom_range(0, 199) == 0) wait_drained();
      sel = $urandom_range(0, 99);
      x0 = $signed(CB'($urandom));
      y0 = $signed(CB'($urandom));
      span = ($urandom_range(0, 19) == 0) ? 300 : 12;
      x1 = clamp_coord(x0 + $urandom_range(0, 2*span) - span);
      y1 = clamp_coord(y0 + $urandom_range(0, 2*span) - span);
      if (sel < 80) begin
        draw_line(x0, y0, x1, y1, 24'($urandom), 1 << 20);
      end else if (sel < 90) begin
        draw_line(x0, y0, x1, y1, 24'($urandom), $urandom_range(0, 4));
      end else if (sel < 95) begin
        step_pixel();
      end else begin
        draw_line(x0, y0, $signed(CB'($urandom)), $signed(CB'($urandom)),
                  24'($urandom), $urandom_range(0, 6));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tuser    = 1'b0;
    s_tdata    = '0;
    items_sent = 0;
    mismatches = 0;
    no_idle    = 1'b0;
    walk_x = '0; walk_y = '0; walk_err = '0; walk_major_end = '0;
    walk_dmajor = '0; walk_dminor = '0; walk_ctrl = '0;
    walk_active = 1'b0; walk_color = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_points_and_idle();
    test_octants();
    test_random_lines();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("** line_rasterizer: PASSED **");
    end else begin
      $display("** line_rasterizer: FAILED **");
    end
    $finish;
  end

endmodule
